// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while en_n is low
`define ASSERT_IMPLY(label, clk, en_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(en_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while en_n is low
`define ASSERT_NEXT(label, clk, en_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(en_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/zrs_pkg.sv =====
`timescale 1ns / 1ps
package zrs_pkg;

  localparam int MAX_KEYS = 1024;
  localparam int KEY_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = KEY_W + 1;
  localparam int FRAC_W   = 32;
  localparam int ACC_W    = FRAC_W + 8;
  localparam int CFG_W    = CNT_W;
  localparam int IDX_W    = 2;
  localparam int Q_W      = FRAC_W + 1;
  localparam int QC_W     = $clog2(Q_W);
  localparam int SQ_W     = CNT_W + FRAC_W;
  localparam int SQ_TOP   = ((SQ_W - 1) / 2) * 2;
  localparam int R1_W     = (SQ_W + 1) / 2;
  localparam int R2_W     = (R1_W + 16 + 1) / 2;
  localparam int D_W      = R1_W + R2_W;

  localparam logic [IDX_W-1:0] REG_KEY_COUNT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_EXP_MODE  = IDX_W'(1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_KEY,
    B_SQ1,
    B_SQ2,
    B_MUL,
    B_DIV,
    B_ACC
  } bld_state_t;

  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    logic [ACC_W-1:0] data;
  } tbl_wr_t;

endpackage

// ===== rtl/zipf_rank_sampler.sv =====
`timescale 1ns / 1ps
// zipf_rank_sampler: maps a uniform 32-bit fraction to a Zipf-distributed rank.
// input channel: in_valid / in_ready with in_uniform_fraction, one word per sample.
// result channel: out_valid / out_ready with out_sampled_rank, one word per sample.
// config port: cfg_we writes cfg_data to register cfg_index (0 key_count,
// 1 exponent_mode); a nonzero key_count write or any exponent_mode write
// starts a rebuild. after reset and after each such write the cumulative
// table is rebuilt, one key at a time, and in_ready stays low meanwhile:
// a key in use goes through a reciprocal for exponent 1.0, and for 0.75
// through two 22-step square roots, a multiply and a 33-step reciprocal;
// unused keys are written with all ones straight from the key state.
// sampling is a 13-stage pipeline: one multiply stage, one add stage, one
// stage per binary search level (each level has its own table slice) and an
// output register; one sample is accepted per cycle unless the pipeline
// holds or a rebuild runs. when out_valid is high and out_ready is low
// the whole pipeline holds; nothing is dropped.
module zipf_rank_sampler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [zrs_pkg::FRAC_W-1:0]    in_uniform_fraction,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [zrs_pkg::KEY_W-1:0]     out_sampled_rank,
  input  logic                          cfg_we,
  input  logic [zrs_pkg::IDX_W-1:0]     cfg_index,
  input  logic [zrs_pkg::CFG_W-1:0]     cfg_data
);

  localparam int KW = zrs_pkg::KEY_W;
  localparam int AW = zrs_pkg::ACC_W;

  logic [zrs_pkg::CNT_W-1:0] kc_r;
  logic                      mode_r;
  logic                      start;
  logic [zrs_pkg::CNT_W-1:0] kc_wr;
  logic                      busy;
  zrs_pkg::tbl_wr_t          wr;
  logic [AW-1:0]             total;
  logic                      en;

  assign kc_wr = (cfg_data > zrs_pkg::CFG_W'(zrs_pkg::MAX_KEYS)) ?
                 zrs_pkg::CNT_W'(zrs_pkg::MAX_KEYS) : cfg_data;
  assign start = cfg_we && (((cfg_index == zrs_pkg::REG_KEY_COUNT) && (cfg_data != '0)) ||
                            (cfg_index == zrs_pkg::REG_EXP_MODE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kc_r   <= zrs_pkg::CNT_W'(zrs_pkg::MAX_KEYS);
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      if ((cfg_index == zrs_pkg::REG_KEY_COUNT) && (cfg_data != '0)) begin
        kc_r <= kc_wr;
      end
      if (cfg_index == zrs_pkg::REG_EXP_MODE) begin
        mode_r <= cfg_data[0];
      end
    end
  end

  zrs_builder u_builder (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kc    (kc_r),
    .mode  (mode_r),
    .busy  (busy),
    .wr    (wr),
    .total (total)
  );

  logic                            out_v_r;
  logic [KW-1:0]                   out_rank_r;
  logic                            p_v_r;
  logic [2*zrs_pkg::FRAC_W-1:0]    p_lo_r;
  logic [AW-1:0]                   p_hi_r;
  logic                            g_v_r;
  logic [AW-1:0]                   g_goal_r;

  assign en        = !out_v_r || out_ready;
  assign in_ready  = en && !busy;
  assign out_valid = out_v_r;
  assign out_sampled_rank = out_rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      g_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= in_valid && !busy;
      g_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r   <= in_uniform_fraction * total[zrs_pkg::FRAC_W-1:0];
      p_hi_r   <= AW'(in_uniform_fraction * total[AW-1:zrs_pkg::FRAC_W]);
      g_goal_r <= p_hi_r + AW'(p_lo_r[2*zrs_pkg::FRAC_W-1:zrs_pkg::FRAC_W]);
    end
  end

  // search stages, stage j decides rank bit KW-1-j
  logic          st_v_r    [KW];
  logic [KW-1:0] st_idx_r  [KW];
  logic [AW-1:0] st_goal_r [KW];
  logic [AW-1:0] st_rd_r   [KW];
  logic [KW-1:0] idx_new   [KW];
  logic [KW-1:0] idx_in    [KW];
  logic [AW-1:0] goal_in   [KW];
  logic          v_in      [KW];

  for (genvar j = 0; j < KW; j++) begin : g_lvl
    localparam int B = KW - 1 - j;
    localparam logic [KW-1:0] MASK = KW'((1 << (B + 1)) - 1);
    localparam logic [KW-1:0] LOW  = KW'((1 << B) - 1);

    if (j == 0) begin : g_first
      assign idx_in[j]  = '0;
      assign goal_in[j] = g_goal_r;
      assign v_in[j]    = g_v_r;
    end else begin : g_next
      assign idx_in[j]  = idx_new[j-1];
      assign goal_in[j] = st_goal_r[j-1];
      assign v_in[j]    = st_v_r[j-1];
    end

    always_comb begin
      idx_new[j]    = st_idx_r[j];
      idx_new[j][B] = st_rd_r[j] <= st_goal_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[j] <= 1'b0;
      end else if (en) begin
        st_v_r[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_idx_r[j]  <= idx_in[j];
        st_goal_r[j] <= goal_in[j];
      end
    end

    // table slice: entries whose low B bits are ones and bit B is zero
    if (B == KW - 1) begin : g_root
      logic [AW-1:0] lvl_mem;
      always_ff @(posedge clk) begin
        if (wr.en && ((wr.key & MASK) == LOW)) begin
          lvl_mem <= wr.data;
        end
        if (en) begin
          st_rd_r[j] <= lvl_mem;
        end
      end
    end else begin : g_slice
      logic [AW-1:0] lvl_mem [2 ** (KW - 1 - B)];
      always_ff @(posedge clk) begin
        if (wr.en && ((wr.key & MASK) == LOW)) begin
          lvl_mem[wr.key[KW-1:B+1]] <= wr.data;
        end
        if (en) begin
          st_rd_r[j] <= lvl_mem[idx_in[j][KW-1:B+1]];
        end
      end
    end
  end

  logic [KW-1:0] kc_m1;
  logic [KW-1:0] rank_fin;

  assign kc_m1    = KW'(kc_r - zrs_pkg::CNT_W'(1));
  assign rank_fin = (idx_new[KW-1] > kc_m1) ? kc_m1 : idx_new[KW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= st_v_r[KW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rank_r <= rank_fin;
    end
  end

endmodule

// ===== rtl/zrs_builder.sv =====
`timescale 1ns / 1ps
module zrs_builder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [zrs_pkg::CNT_W-1:0]   kc,
  input  logic                        mode,
  output logic                        busy,
  output zrs_pkg::tbl_wr_t            wr,
  output logic [zrs_pkg::ACC_W-1:0]   total
);

  zrs_pkg::bld_state_t state_r, state_nxt;

  logic [zrs_pkg::KEY_W-1:0]  k_r;
  logic [zrs_pkg::ACC_W-1:0]  acc_r;
  logic [zrs_pkg::ACC_W-1:0]  total_r;
  logic [zrs_pkg::SQ_W-1:0]   sq_v_r;
  logic [zrs_pkg::SQ_W:0]     sq_res_r;
  logic [zrs_pkg::SQ_W-1:0]   sq_bit_r;
  logic [zrs_pkg::R1_W-1:0]   root1_r;
  logic [zrs_pkg::R2_W-1:0]   root2_r;
  logic [zrs_pkg::D_W-1:0]    d_r;
  logic [zrs_pkg::D_W-1:0]    rem_r;
  logic [zrs_pkg::Q_W-1:0]    q_r;
  logic [zrs_pkg::QC_W-1:0]   cnt_r;

  logic [zrs_pkg::CNT_W-1:0]  n;
  logic                       in_range;
  logic                       last_key;
  logic [zrs_pkg::ACC_W-1:0]  acc_sum;
  logic [zrs_pkg::SQ_W:0]     sq_sum;
  logic                       sq_ge;
  logic [zrs_pkg::SQ_W-1:0]   sq_v_nxt;
  logic [zrs_pkg::SQ_W:0]     sq_res_nxt;
  logic                       div_bit;
  logic [zrs_pkg::D_W:0]      div_t;
  logic                       div_ge;
  logic [zrs_pkg::D_W-1:0]    rem_nxt;

  localparam logic [zrs_pkg::SQ_W-1:0] SQ_START = zrs_pkg::SQ_W'(1) << zrs_pkg::SQ_TOP;

  assign n        = zrs_pkg::CNT_W'(k_r) + zrs_pkg::CNT_W'(1);
  assign in_range = zrs_pkg::CNT_W'(k_r) < kc;
  assign last_key = k_r == zrs_pkg::KEY_W'(zrs_pkg::MAX_KEYS - 1);
  assign acc_sum  = acc_r + zrs_pkg::ACC_W'(q_r);

  // one step of the bit-pair square root
  assign sq_sum     = sq_res_r + {1'b0, sq_bit_r};
  assign sq_ge      = {1'b0, sq_v_r} >= sq_sum;
  assign sq_v_nxt   = sq_ge ? (sq_v_r - sq_sum[zrs_pkg::SQ_W-1:0]) : sq_v_r;
  assign sq_res_nxt = sq_ge ? ((sq_res_r >> 1) + {1'b0, sq_bit_r}) : (sq_res_r >> 1);

  // one quotient bit of the restoring reciprocal
  assign div_bit = !mode && (cnt_r == zrs_pkg::QC_W'(zrs_pkg::Q_W - 1));
  assign div_t   = {rem_r, div_bit};
  assign div_ge  = div_t >= {1'b0, d_r};
  assign rem_nxt = div_ge ? zrs_pkg::D_W'(div_t - {1'b0, d_r}) : zrs_pkg::D_W'(div_t);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zrs_pkg::B_IDLE: state_nxt = zrs_pkg::B_IDLE;
      zrs_pkg::B_KEY: begin
        if (in_range) begin
          state_nxt = mode ? zrs_pkg::B_SQ1 : zrs_pkg::B_DIV;
        end else if (last_key) begin
          state_nxt = zrs_pkg::B_IDLE;
        end
      end
      zrs_pkg::B_SQ1: if (sq_bit_r[0]) state_nxt = zrs_pkg::B_SQ2;
      zrs_pkg::B_SQ2: if (sq_bit_r[0]) state_nxt = zrs_pkg::B_MUL;
      zrs_pkg::B_MUL: state_nxt = zrs_pkg::B_DIV;
      zrs_pkg::B_DIV: if (cnt_r == '0) state_nxt = zrs_pkg::B_ACC;
      zrs_pkg::B_ACC: state_nxt = last_key ? zrs_pkg::B_IDLE : zrs_pkg::B_KEY;
      default: state_nxt = zrs_pkg::B_IDLE;
    endcase
    if (start) begin
      state_nxt = zrs_pkg::B_KEY;
    end
  end

  always_comb begin
    busy    = state_r != zrs_pkg::B_IDLE;
    wr.en   = ((state_r == zrs_pkg::B_KEY) && !in_range) || (state_r == zrs_pkg::B_ACC);
    wr.key  = k_r;
    wr.data = (state_r == zrs_pkg::B_ACC) ? acc_sum : '1;
  end

  assign total = total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zrs_pkg::B_KEY;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        k_r <= '0;
      end else if (!last_key && ((state_r == zrs_pkg::B_ACC) ||
                                 ((state_r == zrs_pkg::B_KEY) && !in_range))) begin
        k_r <= k_r + zrs_pkg::KEY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      acc_r <= '0;
    end else if (state_r == zrs_pkg::B_ACC) begin
      acc_r <= acc_sum;
    end
    case (state_r)
      zrs_pkg::B_KEY: begin
        sq_v_r   <= zrs_pkg::SQ_W'({n, zrs_pkg::FRAC_W'(0)});
        sq_res_r <= '0;
        sq_bit_r <= SQ_START;
        d_r      <= zrs_pkg::D_W'(n);
        rem_r    <= '0;
        q_r      <= '0;
        cnt_r    <= zrs_pkg::QC_W'(zrs_pkg::Q_W - 1);
      end
      zrs_pkg::B_SQ1: begin
        if (sq_bit_r[0]) begin
          root1_r  <= sq_res_nxt[zrs_pkg::R1_W-1:0];
          sq_v_r   <= zrs_pkg::SQ_W'({sq_res_nxt[zrs_pkg::R1_W-1:0], 16'b0});
          sq_res_r <= '0;
          sq_bit_r <= SQ_START;
        end else begin
          sq_v_r   <= sq_v_nxt;
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
        end
      end
      zrs_pkg::B_SQ2: begin
        root2_r  <= sq_res_nxt[zrs_pkg::R2_W-1:0];
        sq_v_r   <= sq_v_nxt;
        sq_res_r <= sq_res_nxt;
        sq_bit_r <= sq_bit_r >> 2;
      end
      zrs_pkg::B_MUL: begin
        d_r   <= zrs_pkg::D_W'(root1_r * root2_r);
        rem_r <= zrs_pkg::D_W'(1) << (zrs_pkg::FRAC_W - 1);
        q_r   <= '0;
        cnt_r <= zrs_pkg::QC_W'(zrs_pkg::Q_W - 1);
      end
      zrs_pkg::B_DIV: begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[zrs_pkg::Q_W-2:0], div_ge};
        cnt_r <= cnt_r - zrs_pkg::QC_W'(1);
      end
      zrs_pkg::B_ACC: begin
        if (zrs_pkg::CNT_W'(k_r) == kc - zrs_pkg::CNT_W'(1)) begin
          total_r <= acc_sum;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/zrs_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module zrs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [zrs_pkg::KEY_W-1:0]     out_sampled_rank,
  input logic                          cfg_we,
  input logic [zrs_pkg::IDX_W-1:0]     cfg_index,
  input logic [zrs_pkg::CFG_W-1:0]     cfg_data
);

  logic rebuild;

  assign rebuild = cfg_we && (((cfg_index == zrs_pkg::REG_KEY_COUNT) && (cfg_data != '0)) ||
                              (cfg_index == zrs_pkg::REG_EXP_MODE));

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sampled_rank), "result word changed while stalled")
  `ASSERT_NEXT(a_rst_build, clk, 1'b1, !rst_n, !in_ready, "input taken right after reset")
  `ASSERT_NEXT(a_rst_out, clk, 1'b1, !rst_n, !out_valid, "result word right after reset")
  `ASSERT_NEXT(a_cfg_build, clk, rst_n, rebuild, !in_ready, "input taken during table rebuild")

endmodule

bind zipf_rank_sampler zrs_checker u_zrs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sampled_rank (out_sampled_rank),
  .cfg_we           (cfg_we),
  .cfg_index        (cfg_index),
  .cfg_data         (cfg_data)
);

// ===== tb/sv/zipf_rank_checker.sv =====
`timescale 1ns / 1ps
module zipf_rank_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [zrs_pkg::FRAC_W-1:0] in_uniform_fraction,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [zrs_pkg::KEY_W-1:0]  out_sampled_rank,
  input  logic                       cfg_we,
  input  logic [zrs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [zrs_pkg::CFG_W-1:0]  cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);

  logic [zrs_pkg::ACC_W-1:0] running_sum [zrs_pkg::MAX_KEYS];
  logic [zrs_pkg::ACC_W-1:0] sum_total;
  int unsigned               num_keys;
  logic                      slow_decay;
  logic [zrs_pkg::KEY_W-1:0] rank_queue [$];
  bit                        table_ready;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned rank_weight(int unsigned k);
    longint unsigned n;
    longint unsigned r1;
    longint unsigned r2;
    longint unsigned prod;
    logic [64:0] quo;
    n = k + 1;
    if (!slow_decay) return (64'd1 << 32) / n;
    r1 = isqrt(n << 32);
    r2 = isqrt(r1 << 16);
    prod = r1 * r2;
    if (prod < 2) return 0;
    quo = {1'b1, 64'd0} / {1'b0, prod};
    return quo[63:0];
  endfunction

  task automatic rebuild_sums();
    logic [zrs_pkg::ACC_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < zrs_pkg::MAX_KEYS; k++) begin
      if (k < num_keys) begin
        acc = acc + rank_weight(k);
        running_sum[k] = acc;
      end else begin
        running_sum[k] = '0;
      end
    end
    sum_total = acc;
  endtask

  function automatic logic [zrs_pkg::KEY_W-1:0] draw_rank(logic [zrs_pkg::FRAC_W-1:0] frac);
    longint unsigned goal;
    int unsigned lo;
    int unsigned hi;
    int unsigned probe;
    goal = longint'(frac) * longint'(sum_total[zrs_pkg::ACC_W-1:zrs_pkg::FRAC_W])
         + ((longint'(frac) * longint'(sum_total[zrs_pkg::FRAC_W-1:0])) >> 32);
    lo = 0;
    hi = num_keys - 1;
    while (lo < hi) begin
      probe = (lo + hi) / 2;
      if (running_sum[probe] > goal) hi = probe;
      else lo = probe + 1;
    end
    return lo[zrs_pkg::KEY_W-1:0];
  endfunction

  assign pending = rank_queue.size();

  always @(posedge clk) begin
    logic [zrs_pkg::KEY_W-1:0] want;
    if (!rst_n) begin
      if (!table_ready) begin
        num_keys = zrs_pkg::MAX_KEYS;
        slow_decay = 1'b0;
        rebuild_sums();
        table_ready = 1'b1;
      end
      rank_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == zrs_pkg::REG_KEY_COUNT && cfg_data != 0) begin
          num_keys = (cfg_data > zrs_pkg::MAX_KEYS) ? zrs_pkg::MAX_KEYS : cfg_data;
          rebuild_sums();
        end else if (cfg_index == zrs_pkg::REG_EXP_MODE) begin
          slow_decay = cfg_data[0];
          rebuild_sums();
        end
      end
      if (in_valid && in_ready) rank_queue.push_back(draw_rank(in_uniform_fraction));
      if (out_valid && out_ready) begin
        checked++;
        if (rank_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word: rank %0d", out_sampled_rank);
        end else begin
          want = rank_queue.pop_front();
          if (want !== out_sampled_rank) begin
            fail_count++;
            if (fail_count <= 10)
              $display("rank mismatch: expected %0d got %0d", want, out_sampled_rank);
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [zrs_pkg::FRAC_W-1:0] in_uniform_fraction;
  logic                       out_valid;
  logic                       out_ready;
  logic [zrs_pkg::KEY_W-1:0]  out_sampled_rank;
  logic                       cfg_we;
  logic [zrs_pkg::IDX_W-1:0]  cfg_index;
  logic [zrs_pkg::CFG_W-1:0]  cfg_data;
  int                         fail_count;
  int                         pending;
  int                         checked;
  int                         sent;
  int                         cycles;
  int                         hold_req;
  bit                         tx_quiet;

  zipf_rank_sampler DUT (.*);

  zipf_rank_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("timeout after %0d cycles", cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // receiver with random stalls and an occasional long hold
  initial begin
    int w;
    bit quiet;
    int holds_done;
    out_ready = 1'b0;
    quiet = 1'b0;
    holds_done = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req > holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if ($urandom_range(0, 40) == 0) quiet = !quiet;
      w = quiet ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_word(logic [zrs_pkg::FRAC_W-1:0] frac);
    int w;
    if ($urandom_range(0, 40) == 0) tx_quiet = !tx_quiet;
    w = tx_quiet ? 0 : $urandom_range(0, 5);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_uniform_fraction <= frac;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [zrs_pkg::IDX_W-1:0] idx, logic [zrs_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_words(int n);
    logic [zrs_pkg::FRAC_W-1:0] f;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: f = $urandom >> $urandom_range(0, 31);
        1: f = ~($urandom >> $urandom_range(0, 31));
        default: f = $urandom;
      endcase
      send_word(f);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_uniform_fraction = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 0;
    tx_quiet = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // extremes and walking bits on the default table
    send_word('0);
    send_word('1);
    send_word(32'd1);
    send_word(32'h8000_0000);
    send_word(32'h7fff_ffff);
    for (int b = 0; b < zrs_pkg::FRAC_W; b += 2) send_word(32'd1 << b);
    random_words(300);
    drain();

    // ignored writes, then the slower decay over all keys
    write_reg(zrs_pkg::REG_KEY_COUNT, '0);
    write_reg(zrs_pkg::IDX_W'(2), '1);
    write_reg(zrs_pkg::IDX_W'(3), zrs_pkg::CFG_W'(5));
    send_word('1);
    send_word('0);
    random_words(40);
    drain();
    write_reg(zrs_pkg::REG_EXP_MODE, zrs_pkg::CFG_W'(1));
    hold_req++;
    random_words(250);
    drain();

    write_reg(zrs_pkg::REG_KEY_COUNT, zrs_pkg::CFG_W'(1));
    send_word('1);
    random_words(100);
    drain();

    write_reg(zrs_pkg::REG_KEY_COUNT, zrs_pkg::CFG_W'(2));
    write_reg(zrs_pkg::REG_EXP_MODE, zrs_pkg::CFG_W'(0));
    send_word('1);
    random_words(150);
    drain();

    // oversize count saturates
    write_reg(zrs_pkg::REG_KEY_COUNT, '1);
    send_word('1);
    random_words(200);
    drain();

    write_reg(zrs_pkg::REG_KEY_COUNT, zrs_pkg::CFG_W'(37));
    write_reg(zrs_pkg::REG_EXP_MODE, zrs_pkg::CFG_W'(1));
    random_words(150);
    drain();

    write_reg(zrs_pkg::REG_KEY_COUNT, zrs_pkg::CFG_W'(513));
    hold_req++;
    random_words(150);
    drain();

    $display("sent %0d fraction words, checked %0d rank words", sent, checked);
    $display("key counts 1 to 1024 and oversize, both exponents, %0d failures", fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
